@@ hdl/atti_pkg.sv @@
// ----------------------------------------------------------------------------
// atti_pkg - shared types and constants for the ADC to temperature converter
// Breakpoint ROM, temperature scale and the record passed from search to math.
// ----------------------------------------------------------------------------
package atti_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int TABLE_ENTRIES = 43;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);

  // temperature scale, in tenths of a degree
  localparam int T_BASE   = -550;
  localparam int T_STRIDE = 50;
  localparam int Q_SCALE  = 1000;
  localparam int Q_SPLIT  = 100;

  // floor(floor(d*Q_SCALE/delta)*step/Q_SPLIT) folds into floor(d*ADD_SCALE/delta)
  localparam int ADD_SCALE = Q_SCALE * (T_STRIDE / 10) / Q_SPLIT;
  localparam int QB        = $clog2(ADD_SCALE);           // quotient bits
  localparam int CNT_BITS  = $clog2(QB);
  localparam int DIVW      = SAMPLE_BITS + QB;            // dividend width

  // result widths
  localparam int TW = 12;   // temp_tenths
  localparam int WW = 9;    // whole_degrees
  localparam int DW = 4;    // tenths_digit

  // divide by ten: floor(n*RECIP10 >> RECIP_SHIFT) is exact for n below 2048
  localparam int RECIP10     = 6554;
  localparam int RECIP_SHIFT = 16;
  localparam int MW          = (TW - 1) + RECIP_SHIFT - 3;

  // queue between search and arithmetic
  localparam int Q_DEPTH = 2;
  localparam int QP_BITS = $clog2(Q_DEPTH);

  localparam logic [SAMPLE_BITS-1:0] BP_ROM [TABLE_ENTRIES] = '{
    10'd10,   10'd15,   10'd21,   10'd29,   10'd40,   10'd54,   10'd73,
    10'd95,   10'd123,  10'd156,  10'd195,  10'd239,  10'd288,  10'd341,
    10'd397,  10'd454,  10'd510,  10'd565,  10'd618,  10'd666,  10'd711,
    10'd751,  10'd787,  10'd818,  10'd846,  10'd870,  10'd890,  10'd908,
    10'd924,  10'd937,  10'd948,  10'd958,  10'd966,  10'd973,  10'd979,
    10'd984,  10'd989,  10'd993,  10'd996,  10'd999,  10'd1002, 10'd1004,
    10'd1006
  };

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);

  // one classified sample
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [IDX_BITS-1:0]    idx;      // lower breakpoint, or the result point
    logic                   interp;   // interpolate between idx and idx+1
    logic                   clo;
    logic                   chi;
  } entry_t;

  function automatic logic [SAMPLE_BITS-1:0] bp_rom(input logic [IDX_BITS-1:0] i);
    logic [SAMPLE_BITS-1:0] v;
    v = '0;
    if (i < IDX_BITS'(TABLE_ENTRIES)) v = BP_ROM[i];
    return v;
  endfunction

  function automatic logic signed [TW-1:0] point_temp(input logic [IDX_BITS-1:0] i);
    return TW'(T_BASE + T_STRIDE * int'(i));
  endfunction

endpackage

@@ hdl/atti_front.sv @@
// ----------------------------------------------------------------------------
// atti_front - sample intake and breakpoint search
// Clamps out-of-range samples, binary-searches the ROM one step per cycle.
// ----------------------------------------------------------------------------
module atti_front import atti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                   busy,
  input  logic                   q_full,
  output logic                   q_push,
  output entry_t                 q_data
);

  localparam logic [1:0] F_IDLE   = 2'd0;
  localparam logic [1:0] F_SEARCH = 2'd1;
  localparam logic [1:0] F_PUSH   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  entry_t              ent_r, ent_nxt;
  logic [IDX_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_BITS:0]   sum;
  logic [IDX_BITS-1:0] mid;

  assign busy   = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = ent_r;

  assign sum = {1'b0, hi_r} + {1'b0, lo_r};
  assign mid = sum[IDX_BITS:1];

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          ent_nxt.sample = in_adc_sample;
          ent_nxt.interp = 1'b0;
          ent_nxt.clo    = 1'b0;
          ent_nxt.chi    = 1'b0;
          lo_nxt         = '0;
          hi_nxt         = IDX_LAST;
          priority if (in_adc_sample >= bp_rom(IDX_LAST)) begin
            ent_nxt.chi = 1'b1;
            ent_nxt.idx = IDX_LAST;
            state_nxt   = F_PUSH;
          end else if (in_adc_sample <= bp_rom('0)) begin
            ent_nxt.clo = 1'b1;
            ent_nxt.idx = '0;
            state_nxt   = F_PUSH;
          end else begin
            state_nxt = F_SEARCH;
          end
        end
      end
      F_SEARCH: begin
        if (IDX_BITS'(hi_r - lo_r) > IDX_BITS'(1)) begin
          if (ent_r.sample > bp_rom(mid)) lo_nxt = mid;
          else                            hi_nxt = mid;
        end else begin
          // sample sitting on the upper breakpoint takes its temperature
          if (ent_r.sample >= bp_rom(hi_r)) begin
            ent_nxt.idx = hi_r;
          end else begin
            ent_nxt.idx    = lo_r;
            ent_nxt.interp = 1'b1;
          end
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ent_r <= ent_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

endmodule

@@ hdl/atti_queue.sv @@
// ----------------------------------------------------------------------------
// atti_queue - short FIFO between search and arithmetic
// Register-based, Q_DEPTH entries, head visible without a pop.
// ----------------------------------------------------------------------------
module atti_queue import atti_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t             mem_r [Q_DEPTH];
  logic [QP_BITS-1:0] wr_r, rd_r;
  logic [QP_BITS:0]   cnt_r;

  assign full  = (cnt_r == (QP_BITS+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QP_BITS'(1);
      if (pop)  rd_r <= rd_r + QP_BITS'(1);
      cnt_r <= cnt_r + (QP_BITS+1)'(push) - (QP_BITS+1)'(pop);
    end
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

@@ hdl/atti_back.sv @@
// ----------------------------------------------------------------------------
// atti_back - interpolation and result formatting
// Serial restoring divide, base temperature add, split into degrees/tenths.
// ----------------------------------------------------------------------------
module atti_back import atti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  entry_t               q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic signed [TW-1:0] out_temp_tenths,
  output logic signed [WW-1:0] out_whole_degrees,
  output logic [DW-1:0]        out_tenths_digit,
  output logic                 out_clamped_low,
  output logic                 out_clamped_high
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_DIV   = 2'd1;
  localparam logic [1:0] B_TEMP  = 2'd2;
  localparam logic [1:0] B_SPLIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [IDX_BITS-1:0]    idx_r, idx_nxt;
  logic                   clo_r, clo_nxt, chi_r, chi_nxt;
  logic [DIVW-1:0]        rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] delta_r, delta_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [QB-1:0]          q_r, q_nxt;
  logic signed [TW-1:0]   t_r, t_nxt;

  logic                   vld_r, vld_nxt;
  logic signed [TW-1:0]   ot_r, ot_nxt;
  logic signed [WW-1:0]   ow_r, ow_nxt;
  logic [DW-1:0]          od_r, od_nxt;
  logic                   oclo_r, oclo_nxt, ochi_r, ochi_nxt;

  logic [SAMPLE_BITS-1:0] vlo, vhi, dsamp, dlt;
  logic [DIVW-1:0]        trial;
  logic [TW-2:0]          mag;
  logic [MW-1:0]          prod;
  logic [WW-2:0]          wmag;

  assign vlo   = bp_rom(q_head.idx);
  assign vhi   = bp_rom(q_head.idx + IDX_BITS'(1));
  assign dsamp = q_head.sample - vlo;
  assign dlt   = vhi - vlo;
  assign trial = DIVW'(delta_r) << cnt_r;

  // magnitude / 10 by reciprocal multiply
  assign mag  = t_r[TW-1] ? (TW-1)'(-t_r) : (TW-1)'(t_r);
  assign prod = MW'(mag) * MW'(RECIP10);
  assign wmag = prod[RECIP_SHIFT +: (WW-1)];

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    clo_nxt   = clo_r;
    chi_nxt   = chi_r;
    rem_nxt   = rem_r;
    delta_nxt = delta_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    t_nxt     = t_r;
    vld_nxt   = 1'b0;
    ot_nxt    = ot_r;
    ow_nxt    = ow_r;
    od_nxt    = od_r;
    oclo_nxt  = oclo_r;
    ochi_nxt  = ochi_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          idx_nxt   = q_head.idx;
          clo_nxt   = q_head.clo;
          chi_nxt   = q_head.chi;
          rem_nxt   = DIVW'(dsamp) * DIVW'(ADD_SCALE);
          delta_nxt = dlt;
          cnt_nxt   = CNT_BITS'(QB - 1);
          q_nxt     = '0;
          // flat interval adds nothing
          if (q_head.interp && (dlt != '0)) state_nxt = B_DIV;
          else                              state_nxt = B_TEMP;
        end
      end
      B_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt      = rem_r - trial;
          q_nxt[cnt_r] = 1'b1;
        end
        if (cnt_r == '0) state_nxt = B_TEMP;
        else             cnt_nxt   = cnt_r - CNT_BITS'(1);
      end
      B_TEMP: begin
        t_nxt     = point_temp(idx_r) + $signed(TW'(q_r));
        state_nxt = B_SPLIT;
      end
      B_SPLIT: begin
        vld_nxt  = 1'b1;
        ot_nxt   = t_r;
        ow_nxt   = t_r[TW-1] ? -$signed(WW'(wmag)) : $signed(WW'(wmag));
        od_nxt   = DW'(mag - (TW-1)'(wmag) * (TW-1)'(10));
        oclo_nxt = clo_r;
        ochi_nxt = chi_r;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    idx_r   <= idx_nxt;
    clo_r   <= clo_nxt;
    chi_r   <= chi_nxt;
    rem_r   <= rem_nxt;
    delta_r <= delta_nxt;
    cnt_r   <= cnt_nxt;
    q_r     <= q_nxt;
    t_r     <= t_nxt;
    ot_r    <= ot_nxt;
    ow_r    <= ow_nxt;
    od_r    <= od_nxt;
    oclo_r  <= oclo_nxt;
    ochi_r  <= ochi_nxt;
  end

  assign out_valid         = vld_r;
  assign out_temp_tenths   = ot_r;
  assign out_whole_degrees = ow_r;
  assign out_tenths_digit  = od_r;
  assign out_clamped_low   = oclo_r;
  assign out_clamped_high  = ochi_r;

endmodule

@@ hdl/adc_to_temperature_table_interp.sv @@
// ----------------------------------------------------------------------------
// adc_to_temperature_table_interp - thermistor ADC reading to temperature
// Piecewise linear lookup in a 43-point breakpoint ROM, 5.0 degree spacing.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_adc_sample and raise start; the transfer happens at the
//   edge where start is high and busy is low. busy then stays high through
//   up to 6 binary-search steps and a final compare against the upper
//   breakpoint (skipped for a clamped sample) and the hand-off to the queue,
//   longer while the queue is full.
//   Output: out_valid pulses for one cycle with temp_tenths, whole_degrees,
//   tenths_digit and the two clamp flags. The receiver cannot stall, so each
//   result must be taken in that cycle.
//   Path from the transfer to out_valid: the search, the queue pop, 6 divide
//   steps (interpolated samples only), the temp add and the split.
//   The search takes a new sample only while busy is low, and the
//   arithmetic unit pops a new entry only after the split of the previous
//   one. A two-entry queue lets a new search overlap the previous sample's
//   division.
//   Reset (rst_n low, synchronous) empties the queue and idles both units;
//   no result is produced for samples in flight.
// ----------------------------------------------------------------------------
module adc_to_temperature_table_interp import atti_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                   out_valid,
  output logic signed [TW-1:0]   out_temp_tenths,
  output logic signed [WW-1:0]   out_whole_degrees,
  output logic [DW-1:0]          out_tenths_digit,
  output logic                   out_clamped_low,
  output logic                   out_clamped_high
);

  // search -> queue -> arithmetic
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;

  // search unit: clamp check at intake, then one bisection step per cycle
  atti_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_adc_sample (in_adc_sample),
    .busy          (busy),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  // decouples the two units so each stalls on its own
  atti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // arithmetic unit: divide, add base temperature, split into digits
  atti_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_temp_tenths   (out_temp_tenths),
    .out_whole_degrees (out_whole_degrees),
    .out_tenths_digit  (out_tenths_digit),
    .out_clamped_low   (out_clamped_low),
    .out_clamped_high  (out_clamped_high)
  );

endmodule
